[hw/rtl/plbe_pkg.sv]
// ----------------------------------------------------------------------------
// plbe_pkg
// Shared types and constants of the parallel led bit encoder.
// ----------------------------------------------------------------------------
package plbe_pkg;

	localparam int LANES_DEF   = 8;
	localparam int BYTE_W      = 8;
	localparam int RC_W        = 12;
	localparam int WORD_W      = 32;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 48;
	localparam int PADDR_W     = 3;

	// register index, taken from paddr[2]
	localparam logic REG_INVERT_MASK  = 1'b0;
	localparam logic REG_RESET_CYCLES = 1'b1;

	localparam logic [RC_W-1:0]   RESET_CYCLES_RST = RC_W'(240);
	localparam logic [BYTE_W-1:0] INVERT_MASK_RST  = '0;

	// one wire word on its way to the output stage
	typedef struct packed {
		logic              valid;
		logic              idle;
		logic              last;
		logic [BYTE_W-1:0] dbits;
		logic [BYTE_W-1:0] active;
		logic [RC_W-1:0]   rc;
	} plbe_word_t;

endpackage

[hw/rtl/plbe_out_stage.sv]
// ----------------------------------------------------------------------------
// plbe_out_stage
// Builds the four-step wire word and holds it in the output register.
// ----------------------------------------------------------------------------
module plbe_out_stage (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  plbe_pkg::plbe_word_t             req,
	input  logic [plbe_pkg::BYTE_W-1:0]      inv,
	output logic                             m_tvalid,
	// [31:0] wire_word, [43:32] repeat_count, [47:44] zero
	output logic [plbe_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                             m_tlast
);
	import plbe_pkg::*;

	logic              valid_s3;
	logic [WORD_W-1:0] word_s3;
	logic [RC_W-1:0]   rc_s3;
	logic              last_s3;
	logic [WORD_W-1:0] word_d;
	logic [BYTE_W-1:0] d_x;

	always_comb begin
		d_x = req.dbits ^ inv;
		if (req.idle) begin
			word_d = {inv, inv, inv, inv};
		end else begin
			word_d = {inv, d_x, d_x, req.active ^ inv};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_s3 <= word_d;
			rc_s3   <= req.rc;
			last_s3 <= req.last;
		end
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = {(OUT_TDATA_W - WORD_W - RC_W)'(0), rc_s3, word_s3};
	assign m_tlast  = last_s3;

endmodule

[hw/rtl/parallel_led_bit_encoder.sv]
// ----------------------------------------------------------------------------
// parallel_led_bit_encoder
// Four-step LED waveform encoder for up to eight parallel lanes.
// ----------------------------------------------------------------------------
// Each accepted byte column with data yields eight wire words, one per bit
// position and MSB first; the last column of a frame adds one idle word when
// reset_cycles is non-zero. A column with an empty mask that is not the last
// one leaves with no output. The path is three register stages: column
// holding register and bit counter, bit-slice stage, and output register.
// The next column is taken in the cycle that the current one sends its final
// word, so columns follow without gaps. Configuration must be written only
// while the block is idle.
module parallel_led_bit_encoder #(
	parameter int LANES = plbe_pkg::LANES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// lane0_byte .. lane7_byte in [63:0], has_data_mask in [71:64]
	input  logic [plbe_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                             s_tvalid,
	input  logic                             s_tlast,
	output logic                             s_tready,
	// [31:0] wire_word, [43:32] repeat_count, [47:44] zero
	output logic [plbe_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                             m_tvalid,
	output logic                             m_tlast,
	input  logic                             m_tready,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [plbe_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import plbe_pkg::*;

	localparam int MASK_LSB = 8 * BYTE_W;

	logic [BYTE_W-1:0] inv_q;
	logic [RC_W-1:0]   rc_q;

	logic                           valid_s1;
	logic [LANES-1:0][BYTE_W-1:0]   lane_s1;
	logic [BYTE_W-1:0]              active_s1;
	logic                           last_s1;
	logic [3:0]                     idx_q;

	plbe_word_t req_s2;
	plbe_word_t req_d;

	logic adv, has_data, rc_nz, emit, is_idle, final_word, consume, in_req;
	logic [2:0] bit_sel;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= INVERT_MASK_RST;
			rc_q  <= RESET_CYCLES_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_INVERT_MASK:  inv_q <= pwdata[BYTE_W-1:0];
				REG_RESET_CYCLES: rc_q  <= pwdata[RC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_INVERT_MASK:  prdata = 32'(inv_q);
			REG_RESET_CYCLES: prdata = 32'(rc_q);
			default:          prdata = '0;
		endcase
	end

	// column sequencing
	assign adv        = !m_tvalid || m_tready;
	assign has_data   = |active_s1;
	assign rc_nz      = |rc_q;
	assign emit       = valid_s1 && (has_data || last_s1);
	assign is_idle    = !has_data || idx_q[3];
	assign final_word = is_idle || (idx_q[2:0] == 3'd7 && !(last_s1 && rc_nz));
	assign consume    = valid_s1 && (!emit || (adv && final_word));
	assign s_tready   = !valid_s1 || consume;
	assign in_req     = s_tvalid && s_tready;
	assign bit_sel    = ~idx_q[2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (in_req) begin
				valid_s1 <= 1'b1;
			end else if (consume) begin
				valid_s1 <= 1'b0;
			end
			if (consume) begin
				idx_q <= '0;
			end else if (emit && adv) begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_req) begin
			for (int l = 0; l < LANES; l++) begin
				lane_s1[l] <= s_tdata[BYTE_W*l +: BYTE_W];
			end
			active_s1 <= BYTE_W'(s_tdata[MASK_LSB +: LANES]);
			last_s1   <= s_tlast;
		end
	end

	// bit slice of the current position across lanes
	always_comb begin
		req_d        = '0;
		req_d.valid  = emit;
		req_d.idle   = is_idle;
		req_d.active = active_s1;
		for (int l = 0; l < LANES; l++) begin
			req_d.dbits[l] = lane_s1[l][bit_sel] & active_s1[l];
		end
		if (is_idle) begin
			req_d.last = 1'b1;
			req_d.rc   = rc_nz ? rc_q : RC_W'(1);
		end else begin
			req_d.last = last_s1 && !rc_nz && (idx_q[2:0] == 3'd7);
			req_d.rc   = RC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s2 <= '0;
		end else if (adv) begin
			req_s2 <= req_d;
		end
	end

	plbe_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.req      (req_s2),
		.inv      (inv_q),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
